// ----- hw/rtl/dsu32_pkg.sv -----
package dsu32_pkg;

  localparam int unsigned MaxDigits = 10;

  localparam logic [15:0] CharZero = 16'h0030;
  localparam logic [15:0] CharNine = 16'h0039;
  localparam logic [3:0]  CountSat = 4'd15;
  localparam logic [3:0]  CountMax = 4'(MaxDigits);

  typedef struct packed {
    logic [15:0] ch;
    logic        last;
  } in_beat_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] value;
  } out_beat_t;

endpackage

// ----- hw/rtl/decimal_string_to_uint32_unit.sv -----
// channel | dir | valid     | stall     | payload
// --------+-----+-----------+-----------+---------------------------------
// in      | in  | in_valid  | in_stall  | in_data  (ch, last)
// out     | out | out_valid | out_stall | out_data (ok, value)
//
// One character per cycle while in_stall is low; a string's result appears in the
// cycle after its last character, from the single multiply-by-ten-and-add stage on accum.
// Reset (rst, synchronous) clears the running state and out_valid; out_data is not reset.
// in_stall rises only for a last character while the held result is stalled;
// other characters keep flowing since they produce no result.
module decimal_string_to_uint32_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  dsu32_pkg::in_beat_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output dsu32_pkg::out_beat_t out_data
);

  logic [31:0] accum;
  logic [3:0]  char_count;
  logic        bad_flag;

  logic [31:0] accum_next;
  logic [3:0]  char_count_next;
  logic        bad_flag_next;

  logic        in_fire;
  logic        out_fire;
  logic        is_digit;
  logic        is_first;
  logic        bad_pre;
  logic [35:0] prod;

  assign in_stall = out_valid && out_stall && in_data.last;
  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;

  assign is_digit = (in_data.ch >= dsu32_pkg::CharZero) && (in_data.ch <= dsu32_pkg::CharNine);
  assign is_first = (char_count == 4'd0);

  // x*10 = x*8 + x*2, then add the digit
  assign prod = {1'b0, accum, 3'b000} + {3'b000, accum, 1'b0} + {32'd0, in_data.ch[3:0]};

  always_comb begin
    bad_pre = bad_flag
           || (char_count >= dsu32_pkg::CountMax)
           || !is_digit
           || (is_first && (in_data.ch == dsu32_pkg::CharZero) && !in_data.last);
    accum_next    = accum;
    bad_flag_next = bad_pre;
    if (!bad_pre) begin
      if (prod[35:32] != 4'd0) begin
        bad_flag_next = 1'b1;
      end else begin
        accum_next = prod[31:0];
      end
    end
    char_count_next = (char_count < dsu32_pkg::CountSat) ? char_count + 4'd1 : char_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accum      <= '0;
      char_count <= '0;
      bad_flag   <= 1'b0;
    end else if (in_fire) begin
      if (in_data.last) begin
        accum      <= '0;
        char_count <= '0;
        bad_flag   <= 1'b0;
      end else begin
        accum      <= accum_next;
        char_count <= char_count_next;
        bad_flag   <= bad_flag_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && in_data.last) begin
      out_valid <= 1'b1;
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_data.last) begin
      out_data.ok    <= !bad_flag_next;
      out_data.value <= bad_flag_next ? 32'd0 : accum_next;
    end
  end

endmodule

// ----- hw/rtl/dsu32_checker.sv -----
module dsu32_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_stall,
  input dsu32_pkg::in_beat_t  in_data,
  input logic                 out_valid,
  input logic                 out_stall,
  input dsu32_pkg::out_beat_t out_data
);

  // held result beat stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.ok |-> out_data.value == 32'd0)
    else $error("rejected string with nonzero value");

  a_last_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_data.last |=> out_valid)
    else $error("last character gave no result");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall && in_data.last)
    else $error("input stalled without a blocked result");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind decimal_string_to_uint32_unit dsu32_checker u_dsu32_checker (.*);

// ----- test/dsu32_checker.sv -----
`timescale 1ns / 100ps

module dsu32_scoreboard (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  dsu32_pkg::in_beat_t  in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  dsu32_pkg::out_beat_t out_data,
  output int                   mismatches,
  output int                   pending
);

  logic [31:0]          run_value;
  logic [3:0]           run_count;
  logic                 run_bad;
  dsu32_pkg::out_beat_t parsed_q[$];

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  task automatic clear_run();
    run_value = '0;
    run_count = '0;
    run_bad   = 1'b0;
  endtask

  // Fold one character into the running parse; a last beat yields a result.
  task automatic parse_char(input dsu32_pkg::in_beat_t b);
    logic [63:0]          wide;
    dsu32_pkg::out_beat_t res;
    if (run_count >= dsu32_pkg::CountMax) run_bad = 1'b1;
    if (b.ch < dsu32_pkg::CharZero || b.ch > dsu32_pkg::CharNine) run_bad = 1'b1;
    if (run_count == 4'd0 && b.ch == dsu32_pkg::CharZero && !b.last) run_bad = 1'b1;
    if (!run_bad) begin
      wide = 64'(run_value) * 64'd10 + 64'(b.ch - dsu32_pkg::CharZero);
      if (wide[63:32] != 32'd0) run_bad = 1'b1;
      else run_value = wide[31:0];
    end
    if (run_count != dsu32_pkg::CountSat) run_count = run_count + 4'd1;
    if (b.last) begin
      res.ok    = !run_bad;
      res.value = run_bad ? 32'd0 : run_value;
      parsed_q.push_back(res);
      clear_run();
    end
  endtask

  task automatic note_fail(input string what, input dsu32_pkg::out_beat_t want,
                           input dsu32_pkg::out_beat_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: expected ok=%0b value=%0d, got ok=%0b value=%0d",
               $realtime, what, want.ok, want.value, got.ok, got.value);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_run();
      parsed_q.delete();
    end else begin
      if (in_valid && !in_stall) parse_char(in_data);
      if (out_valid && !out_stall) begin
        if (parsed_q.size() == 0) note_fail("unexpected result", '0, out_data);
        else if (parsed_q[0].ok !== out_data.ok || parsed_q[0].value !== out_data.value)
          note_fail("result mismatch", parsed_q.pop_front(), out_data);
        else void'(parsed_q.pop_front());
      end
    end
    pending = parsed_q.size();
  end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

  localparam int CycleLimit = 200000;
  localparam int BeatTarget = 1520;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  dsu32_pkg::in_beat_t  in_data   = '0;
  logic                 out_stall = 1'b0;
  logic                 in_stall;
  logic                 out_valid;
  dsu32_pkg::out_beat_t out_data;

  int mismatches;
  int pending;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_len      = 0;
  int beats_sent    = 0;
  int cycle_cnt     = 0;

  logic [15:0] str_q[$];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  decimal_string_to_uint32_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  dsu32_scoreboard u_scoreboard (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // Receiver: random stalls, or a long hold-off while hold_len runs down.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_len != 0) begin
      out_stall <= 1'b1;
      hold_len  <= hold_len - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_beat(input logic [15:0] c, input logic l);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{ch: c, last: l};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  task automatic send_str();
    foreach (str_q[i]) send_beat(str_q[i], i == str_q.size() - 1);
    str_q.delete();
  endtask

  task automatic push_number(input longint unsigned n);
    int start;
    start = str_q.size();
    do begin
      str_q.insert(start, dsu32_pkg::CharZero + 16'(n % 10));
      n = n / 10;
    end while (n != 0);
  endtask

  task automatic push_digits(input int len, input bit lead_ok);
    for (int i = 0; i < len; i++)
      str_q.push_back(dsu32_pkg::CharZero + 16'((i == 0 && !lead_ok && len > 1) ?
                                     $urandom_range(1, 9) : $urandom_range(9)));
  endtask

  task automatic random_string();
    int kind;
    int pos;
    kind = $urandom_range(99);
    if (kind < 35) begin
      push_digits($urandom_range(1, 9), 1'b0);
    end else if (kind < 50) begin
      // straddles the 32-bit limit
      push_number(64'd4294967295 - 64'd3000 + 64'($urandom_range(6000)));
    end else if (kind < 60) begin
      push_number(64'($urandom));
    end else if (kind < 67) begin
      push_digits($urandom_range(11, 20), 1'b0);
    end else if (kind < 74) begin
      str_q.push_back(dsu32_pkg::CharZero);
      push_digits($urandom_range(1, 9), 1'b1);
    end else if (kind < 84) begin
      push_digits($urandom_range(1, 10), 1'b0);
      pos = $urandom_range(str_q.size() - 1);
      case ($urandom_range(3))
        0: str_q[pos] = dsu32_pkg::CharZero - 16'd1;
        1: str_q[pos] = dsu32_pkg::CharNine + 16'd1;
        2: str_q[pos] = 16'($urandom);
        default: str_q[pos] = dsu32_pkg::CharZero ^ (16'd1 << $urandom_range(4, 15));
      endcase
    end else begin
      repeat ($urandom_range(1, 12))
        str_q.push_back($urandom_range(1) ? 16'($urandom) :
                        dsu32_pkg::CharZero + 16'($urandom_range(9)));
    end
    send_str();
  endtask

  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    push_number(64'd0);
    send_str();
    str_q = '{dsu32_pkg::CharZero, dsu32_pkg::CharZero + 16'd7};
    send_str();
    push_number(64'd4294967295);
    send_str();
    push_number(64'd4294967296);
    send_str();
    str_q = '{16'hFFFF};
    send_str();
    str_q = '{16'h0000, dsu32_pkg::CharZero + 16'd1};
    send_str();
    str_q = '{dsu32_pkg::CharZero - 16'd1};
    send_str();
    str_q = '{dsu32_pkg::CharNine + 16'd1};
    send_str();
    push_number(64'd9);
    send_str();

    // Long hold-off: the held result blocks the next string's last beat.
    hold_len = 300;
    repeat (4) random_string();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 53; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 53; end
        default: begin send_idle_pct = 17; stall_pct = 17; end
      endcase
      while (beats_sent < BeatTarget * (ph + 1) / 4) random_string();
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/dsu32_pkg.sv
hw/rtl/decimal_string_to_uint32_unit.sv
hw/rtl/dsu32_checker.sv
test/dsu32_checker.sv
test/testbench.sv
